// ----- rtl/mtt_pkg.sv -----
// ----------------------------------------------------------------------------
// Millisecond tick timer package
// Shared payload types, configuration codes and the prescaler table.
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int TIMER_BITS_DEF = 8;
    localparam int MS_BITS_DEF    = 32;
    localparam int CNT_W          = 16;
    localparam int CFG_DATA_W     = 11;
    localparam int DIV_W          = 11;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_PAUSE  = 2'd1;
    localparam logic [1:0] CMD_RESUME = 2'd2;

    localparam logic [1:0] REG_PRESCALE_SELECT = 2'd0;
    localparam logic [1:0] REG_COMPARE_TOP     = 2'd1;
    localparam logic [1:0] REG_US_PER_COUNT    = 2'd2;

    localparam logic [1:0]  RST_PRESCALE_SELECT = 2'd1;
    localparam logic [7:0]  RST_COMPARE_TOP     = 8'd249;
    localparam logic [10:0] RST_US_PER_COUNT    = 11'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] comp_ticks;
    } t_in;

    typedef struct packed {
        logic [31:0] ms_count;
        logic [31:0] micros;
        logic        running;
    } t_out;

    typedef struct packed {
        logic [1:0]  prescale_select;
        logic [7:0]  compare_top;
        logic [10:0] us_per_count;
    } t_cfg;

    typedef struct packed {
        logic [31:0]      ms32;
        logic [CNT_W-1:0] count;
        logic             running;
    } t_snap;

    function automatic logic [DIV_W-1:0] prescale_div(input logic [1:0] sel);
        logic [DIV_W-1:0] d;
        case (sel)
            2'd0:    d = 11'd8;
            2'd1:    d = 11'd64;
            2'd2:    d = 11'd256;
            default: d = 11'd1024;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/millisecond_tick_timer_unit.sv -----
// ----------------------------------------------------------------------------
// Millisecond tick timer unit
// System tick timer with selectable prescaler, compare top, pause and resume.
// ----------------------------------------------------------------------------
// The input channel carries one command per transaction: a CPU clock tick,
// a pause or a resume with a compensation count. A transaction takes place
// when i_valid is high and o_stall is low. Every command yields exactly one
// result transaction on the output channel (o_valid high, i_stall low) with
// the millisecond count, the microsecond time and the running flag after
// that command has been applied.
// The unit accepts one command every cycle while o_stall is low. The counter
// state updates in the cycle of acceptance; the result appears after a
// snapshot stage, a stage for the two products and the output register.
// When the receiver stalls, the stages fill up and o_stall rises only once
// all three hold a result, so up to three commands are buffered.
// Configuration registers are written through the cfg channel, which is
// always ready, and should only be changed while the unit is idle.
// Synchronous reset clears the pipeline and the counters, sets the unit
// running and loads prescaler select 1, compare top 249 and 4 us per count.
// ----------------------------------------------------------------------------
module millisecond_tick_timer_unit #(
    parameter int TIMER_BITS = mtt_pkg::TIMER_BITS_DEF,
    parameter int MS_BITS    = mtt_pkg::MS_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  mtt_pkg::t_in                 i_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output mtt_pkg::t_out                o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [mtt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mtt_pkg::*;

    t_cfg        r_cfg;
    t_snap       snap;
    logic        accept;

    logic        r_a_valid;
    t_snap       r_a;
    logic        r_b_valid;
    logic [31:0] r_b_ms;
    logic [31:0] r_b_pms;
    logic [31:0] r_b_frac;
    logic        r_b_running;
    logic        r_o_valid;
    t_out        r_o;

    logic        ready_o;
    logic        ready_b;
    logic        ready_a;

    assign ready_o = !r_o_valid || !i_stall;
    assign ready_b = !r_b_valid || ready_o;
    assign ready_a = !r_a_valid || ready_b;
    assign o_stall = !ready_a;
    assign accept  = i_valid && ready_a;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescale_select <= RST_PRESCALE_SELECT;
            r_cfg.compare_top     <= RST_COMPARE_TOP;
            r_cfg.us_per_count    <= RST_US_PER_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PRESCALE_SELECT: r_cfg.prescale_select <= i_cfg_data[1:0];
                REG_COMPARE_TOP:     r_cfg.compare_top     <= i_cfg_data[7:0];
                REG_US_PER_COUNT:    r_cfg.us_per_count    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mtt_counter #(
        .TIMER_BITS(TIMER_BITS),
        .MS_BITS   (MS_BITS)
    ) u_counter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (accept),
        .i_in   (i_in),
        .i_cfg  (r_cfg),
        .o_snap (snap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (ready_o) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= snap;
        end
        if (ready_b && r_a_valid) begin
            r_b_ms      <= r_a.ms32;
            r_b_pms     <= r_a.ms32 * 32'd1000;
            r_b_frac    <= 32'(r_a.count) * 32'(r_cfg.us_per_count);
            r_b_running <= r_a.running;
        end
        if (ready_o && r_b_valid) begin
            r_o.ms_count <= r_b_ms;
            r_o.micros   <= r_b_pms + r_b_frac;
            r_o.running  <= r_b_running;
        end
    end

    assign o_valid = r_o_valid;
    assign o_out   = r_o;

endmodule

// ----- rtl/mtt_counter.sv -----
// ----------------------------------------------------------------------------
// Millisecond tick timer counter
// Holds the prescaler, timer counter, millisecond count and pause flag, and
// presents the state that results from the current item.
// ----------------------------------------------------------------------------
module mtt_counter #(
    parameter int TIMER_BITS = mtt_pkg::TIMER_BITS_DEF,
    parameter int MS_BITS    = mtt_pkg::MS_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  mtt_pkg::t_in  i_in,
    input  mtt_pkg::t_cfg i_cfg,
    output mtt_pkg::t_snap o_snap
);
    import mtt_pkg::*;

    logic [9:0]            r_pre;
    logic [9:0]            n_pre;
    logic [TIMER_BITS-1:0] r_cnt;
    logic [TIMER_BITS-1:0] n_cnt;
    logic [MS_BITS-1:0]    r_ms;
    logic [MS_BITS-1:0]    n_ms;
    logic                  r_paused;
    logic                  n_paused;

    logic [15:0]           cmp_ext;
    logic [TIMER_BITS-1:0] cmp;
    logic [DIV_W-1:0]      pre_inc;
    logic [63:0]           ms_ext;

    assign cmp_ext = 16'(i_cfg.compare_top);
    assign cmp     = cmp_ext[TIMER_BITS-1:0];
    assign pre_inc = {1'b0, r_pre} + 11'd1;

    always_comb begin
        n_pre    = r_pre;
        n_cnt    = r_cnt;
        n_ms     = r_ms;
        n_paused = r_paused;
        case (i_in.cmd)
            CMD_TICK: begin
                if (!r_paused) begin
                    if (pre_inc >= prescale_div(i_cfg.prescale_select)) begin
                        n_pre = '0;
                        if (r_cnt == cmp) begin
                            n_cnt = '0;
                            n_ms  = r_ms + MS_BITS'(1);
                        end else begin
                            n_cnt = r_cnt + TIMER_BITS'(1);
                        end
                    end else begin
                        n_pre = pre_inc[9:0];
                    end
                end
            end
            CMD_PAUSE: begin
                n_paused = 1'b1;
            end
            CMD_RESUME: begin
                if (r_paused) begin
                    n_ms     = r_ms + MS_BITS'(i_in.comp_ticks);
                    n_paused = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre    <= '0;
            r_cnt    <= '0;
            r_ms     <= '0;
            r_paused <= 1'b0;
        end else if (i_en) begin
            r_pre    <= n_pre;
            r_cnt    <= n_cnt;
            r_ms     <= n_ms;
            r_paused <= n_paused;
        end
    end

    assign ms_ext          = 64'(n_ms);
    assign o_snap.ms32     = ms_ext[31:0];
    assign o_snap.count    = CNT_W'(n_cnt);
    assign o_snap.running  = ~n_paused;

endmodule
